>>> rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants of the quadratic root solver
// solution codes, operand form codes, the sideband structs that travel down
// the cell chains and a small magnitude helper
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COEF_W    = 32;
	// b^2 + 4|a||c| stays below 2^65
	localparam int DISC_W    = 65;
	// second divider holds 2|a|, |a|, |b|, 1 or 2^frac_bits
	localparam int DEN2_W    = 33;

	// solution kind codes
	localparam logic [2:0] KIND_TWO    = 3'd0;
	localparam logic [2:0] KIND_ONE    = 3'd1;
	localparam logic [2:0] KIND_NONE   = 3'd2;
	localparam logic [2:0] KIND_CONTRA = 3'd3;
	localparam logic [2:0] KIND_INF    = 3'd4;

	// operand form codes, selecting how the roots are built
	localparam logic [2:0] FORM_FULL  = 3'd0;
	localparam logic [2:0] FORM_CZERO = 3'd1;
	localparam logic [2:0] FORM_BZERO = 3'd2;
	localparam logic [2:0] FORM_LIN   = 3'd3;
	localparam logic [2:0] FORM_TRIV  = 3'd4;

	localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [2:0]         kind;
		logic [2:0]         form;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic [DISC_W-1:0]  disc;
	} side_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] neg;
	} tail_t;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

endpackage

>>> rtl/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front: operand decode, products and discriminant
// two stages: classify and multiply, then form the discriminant
// ----------------------------------------------------------------------------
module qrs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_in,
	input  logic signed [31:0]  coef_a,
	input  logic signed [31:0]  coef_b,
	input  logic signed [31:0]  coef_c,
	output logic                valid_s2,
	output qrs_pkg::side_t      side_s2
);

	logic               a_zero, b_zero, c_zero;
	logic [2:0]         form_d, kind_d;
	logic [63:0]        prod_ac_d, sq_b_d;

	logic               valid_s1;
	logic [2:0]         form_s1, kind_s1;
	logic signed [31:0] a_s1, b_s1, c_s1;
	logic [63:0]        prod_ac_s1, sq_b_s1;

	logic [65:0]        disc_d;
	logic               neg_prod;
	qrs_pkg::side_t     side_d;

	assign a_zero = (coef_a == '0);
	assign b_zero = (coef_b == '0);
	assign c_zero = (coef_c == '0);

	always_comb begin
		form_d = qrs_pkg::FORM_TRIV;
		kind_d = qrs_pkg::KIND_INF;
		if (!a_zero && !b_zero && !c_zero) begin
			form_d = qrs_pkg::FORM_FULL;
			kind_d = qrs_pkg::KIND_TWO;
		end else if (!a_zero && !b_zero) begin
			form_d = qrs_pkg::FORM_CZERO;
			kind_d = qrs_pkg::KIND_TWO;
		end else if (!a_zero && !c_zero) begin
			if (coef_a[31] == coef_c[31]) begin
				kind_d = qrs_pkg::KIND_NONE;
			end else begin
				form_d = qrs_pkg::FORM_BZERO;
				kind_d = qrs_pkg::KIND_TWO;
			end
		end else if (!a_zero || (!b_zero && c_zero)) begin
			kind_d = qrs_pkg::KIND_ONE;
		end else if (!b_zero) begin
			form_d = qrs_pkg::FORM_LIN;
			kind_d = qrs_pkg::KIND_ONE;
		end else if (!c_zero) begin
			kind_d = qrs_pkg::KIND_CONTRA;
		end
	end

	assign prod_ac_d = 64'(qrs_pkg::mag32(coef_a)) * 64'(qrs_pkg::mag32(coef_c));
	assign sq_b_d    = 64'(qrs_pkg::mag32(coef_b)) * 64'(qrs_pkg::mag32(coef_b));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			form_s1    <= form_d;
			kind_s1    <= kind_d;
			a_s1       <= coef_a;
			b_s1       <= coef_b;
			c_s1       <= coef_c;
			prod_ac_s1 <= prod_ac_d;
			sq_b_s1    <= sq_b_d;
		end
	end

	// b^2 - 4ac, exact in 66 bits
	assign neg_prod = a_s1[31] ^ c_s1[31];
	assign disc_d   = neg_prod ? ({2'b00, sq_b_s1} + {prod_ac_s1, 2'b00})
				: ({2'b00, sq_b_s1} - {prod_ac_s1, 2'b00});

	always_comb begin
		side_d.kind = kind_s1;
		side_d.form = form_s1;
		side_d.a    = a_s1;
		side_d.b    = b_s1;
		side_d.c    = c_s1;
		side_d.disc = disc_d[qrs_pkg::DISC_W-1:0];
		if (form_s1 == qrs_pkg::FORM_FULL && disc_d[65]) begin
			side_d.kind = qrs_pkg::KIND_NONE;
			side_d.form = qrs_pkg::FORM_TRIV;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_d;
		end
	end

endmodule

>>> rtl/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell: one restoring division step
// shifts one numerator bit into the remainder and one quotient bit into the
// numerator word, for each lane against a shared divisor
// ----------------------------------------------------------------------------
module qrs_div_cell #(
	parameter int  DW    = 32,
	parameter int  NW    = 48,
	parameter int  LANES = 1,
	parameter type side_t = qrs_pkg::side_t
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         valid_in,
	input  side_t                        side_in,
	input  logic [DW-1:0]                den_in,
	input  logic [LANES-1:0][DW-1:0]     rem_in,
	input  logic [LANES-1:0][NW-1:0]     num_in,
	output logic                         valid_q,
	output side_t                        side_q,
	output logic [DW-1:0]                den_q,
	output logic [LANES-1:0][DW-1:0]     rem_q,
	output logic [LANES-1:0][NW-1:0]     num_q
);

	logic [LANES-1:0][DW:0]   trial;
	logic [LANES-1:0][DW+1:0] diff;
	logic [LANES-1:0]         ge;
	logic [LANES-1:0][DW-1:0] rem_next;
	logic [LANES-1:0][NW-1:0] num_next;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			trial[i]    = {rem_in[i], num_in[i][NW-1]};
			diff[i]     = {1'b0, trial[i]} - {2'b00, den_in};
			ge[i]       = ~diff[i][DW+1];
			rem_next[i] = ge[i] ? diff[i][DW-1:0] : trial[i][DW-1:0];
			num_next[i] = {num_in[i][NW-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_in;
			den_q  <= den_in;
			rem_q  <= rem_next;
			num_q  <= num_next;
		end
	end

endmodule

>>> rtl/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell: one digit-by-digit square root step
// brings down two radicand bits and decides one root bit
// ----------------------------------------------------------------------------
module qrs_sqrt_cell #(
	parameter int  SW = 66,
	parameter type side_t = qrs_pkg::side_t,
	localparam int RW  = SW / 2,
	localparam int RMW = RW + 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid_in,
	input  side_t            side_in,
	input  logic [SW-1:0]    rad_in,
	input  logic [RMW-1:0]   rem_in,
	input  logic [RW-1:0]    root_in,
	output logic             valid_q,
	output side_t            side_q,
	output logic [SW-1:0]    rad_q,
	output logic [RMW-1:0]   rem_q,
	output logic [RW-1:0]    root_q
);

	logic [RMW+1:0] acc;
	logic [RMW+1:0] trial;
	logic [RMW+2:0] diff;
	logic           ge;

	assign acc   = {rem_in, rad_in[SW-1:SW-2]};
	assign trial = {2'b00, root_in, 2'b01};
	assign diff  = {1'b0, acc} - {1'b0, trial};
	assign ge    = ~diff[RMW+2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_in;
			rad_q  <= {rad_in[SW-3:0], 2'b00};
			rem_q  <= ge ? diff[RMW-1:0] : acc[RMW-1:0];
			root_q <= {root_in[RW-2:0], ge};
		end
	end

endmodule

>>> rtl/quadratic_root_solver_top.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_top: real roots of a*x^2 + b*x + c = 0
// fixed-point solver built as one long chain of divide and square root cells
// ----------------------------------------------------------------------------
// usage
//  - request channel: coef_a, coef_b, coef_c (signed, FRAC_BITS fraction
//    bits) under coef_valid / coef_stall; taken when valid and not stalled
//  - result channel: solution_kind, root_first, root_second, overflow under
//    root_valid / root_stall, one result for every request, in order
//  - throughput: one request per cycle unless a result waits under root_stall
//  - path: two front stages, the first divider, R = max(33, 16+F) square
//    root cells with F = FRAC_BITS, a numerator set-up register, the second
//    divider over M = max(34, 16+F) magnitude bits, an output register; the
//    two restoring dividers and the square root chain give one quotient or root bit per cell
//  - stall: the whole chain moves as one; while a finished result waits
//    under root_stall every cell holds and coef_stall is raised, and a new
//    request is taken in the same cycle that the waiting result leaves
//  - reset (arst_n low): all valid bits clear, no result is pending, the
//    block takes requests straight away
// ----------------------------------------------------------------------------
module quadratic_root_solver_top #(
	parameter int FRAC_BITS = qrs_pkg::FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               coef_valid,
	output logic               coef_stall,
	input  logic signed [31:0] coef_a,
	input  logic signed [31:0] coef_b,
	input  logic signed [31:0] coef_c,
	output logic               root_valid,
	input  logic               root_stall,
	output logic [2:0]         solution_kind,
	output logic signed [31:0] root_first,
	output logic signed [31:0] root_second,
	output logic               overflow
);

	// first divider: |c| * 2^F / |a| for the b-zero form
	localparam int DW1  = qrs_pkg::COEF_W;
	localparam int NW1  = qrs_pkg::COEF_W + FRAC_BITS;
	// square root: discriminant or that quotient scaled by 2^F
	localparam int SQ_W = (2 * FRAC_BITS + 32 > 66) ? 2 * FRAC_BITS + 32 : 66;
	localparam int RT_W = SQ_W / 2;
	localparam int RM_W = RT_W + 2;
	// second divider: root numerator magnitude, then scaled by 2^F
	localparam int MW2  = (FRAC_BITS + 16 > 34) ? FRAC_BITS + 16 : 34;
	localparam int NW2  = MW2 + FRAC_BITS;
	localparam int DW2  = qrs_pkg::DEN2_W;
	localparam int NS   = MW2 + 2;

	logic en;

	// whole chain advances unless a result is held back
	assign en         = ~root_valid | ~root_stall;
	assign coef_stall = ~en;

	// ---------------------------------------------------------------- front
	logic           fr_valid;
	qrs_pkg::side_t fr_side;

	qrs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (coef_valid & en),
		.coef_a   (coef_a),
		.coef_b   (coef_b),
		.coef_c   (coef_c),
		.valid_s2 (fr_valid),
		.side_s2  (fr_side)
	);

	// ------------------------------------------------------- first divider
	logic                   d1_valid [0:NW1];
	qrs_pkg::side_t         d1_side  [0:NW1];
	logic [DW1-1:0]         d1_den   [0:NW1];
	logic [0:0][DW1-1:0]    d1_rem   [0:NW1];
	logic [0:0][NW1-1:0]    d1_num   [0:NW1];

	assign d1_valid[0]  = fr_valid;
	assign d1_side[0]   = fr_side;
	assign d1_den[0]    = qrs_pkg::mag32(fr_side.a);
	assign d1_rem[0][0] = '0;
	assign d1_num[0][0] = {qrs_pkg::mag32(fr_side.c), {FRAC_BITS{1'b0}}};

	for (genvar k = 0; k < NW1; k++) begin : g_div1
		qrs_div_cell #(
			.DW     (DW1),
			.NW     (NW1),
			.LANES  (1),
			.side_t (qrs_pkg::side_t)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (d1_valid[k]),
			.side_in  (d1_side[k]),
			.den_in   (d1_den[k]),
			.rem_in   (d1_rem[k]),
			.num_in   (d1_num[k]),
			.valid_q  (d1_valid[k+1]),
			.side_q   (d1_side[k+1]),
			.den_q    (d1_den[k+1]),
			.rem_q    (d1_rem[k+1]),
			.num_q    (d1_num[k+1])
		);
	end

	// --------------------------------------------------------- square root
	logic               sq_valid [0:RT_W];
	qrs_pkg::side_t     sq_side  [0:RT_W];
	logic [SQ_W-1:0]    sq_rad   [0:RT_W];
	logic [RM_W-1:0]    sq_rem   [0:RT_W];
	logic [RT_W-1:0]    sq_root  [0:RT_W];

	assign sq_valid[0] = d1_valid[NW1];
	assign sq_side[0]  = d1_side[NW1];
	// b-zero form takes floor(|c| * 2^F / |a|) scaled by 2^F, the rest the discriminant
	assign sq_rad[0]   = (d1_side[NW1].form == qrs_pkg::FORM_BZERO)
			? SQ_W'({d1_num[NW1][0], {FRAC_BITS{1'b0}}})
			: SQ_W'(d1_side[NW1].disc);
	assign sq_rem[0]   = '0;
	assign sq_root[0]  = '0;

	for (genvar k = 0; k < RT_W; k++) begin : g_sqrt
		qrs_sqrt_cell #(
			.SW     (SQ_W),
			.side_t (qrs_pkg::side_t)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (sq_valid[k]),
			.side_in  (sq_side[k]),
			.rad_in   (sq_rad[k]),
			.rem_in   (sq_rem[k]),
			.root_in  (sq_root[k]),
			.valid_q  (sq_valid[k+1]),
			.side_q   (sq_side[k+1]),
			.rad_q    (sq_rad[k+1]),
			.rem_q    (sq_rem[k+1]),
			.root_q   (sq_root[k+1])
		);
	end

	// ------------------------------------------------ numerator set-up
	qrs_pkg::side_t       sq_last;
	logic signed [NS-1:0] b_x, c_x, s_x;
	logic signed [NS-1:0] n1, n2, m1, m2;
	logic [DW2-1:0]       den_d;
	logic                 den_neg;
	qrs_pkg::tail_t       tail_d;

	logic                 pre_valid_q;
	qrs_pkg::tail_t       pre_tail_q;
	logic [DW2-1:0]       pre_den_q;
	logic [1:0][NW2-1:0]  pre_num_q;

	assign sq_last = sq_side[RT_W];
	assign b_x     = NS'(sq_last.b);
	assign c_x     = NS'(sq_last.c);
	assign s_x     = signed'(NS'(sq_root[RT_W]));

	always_comb begin
		n1      = '0;
		n2      = '0;
		den_d   = DW2'(1);
		den_neg = 1'b0;
		case (sq_last.form)
			qrs_pkg::FORM_FULL: begin
				// (-b +/- sqrt(d)) / 2a
				n1      = s_x - b_x;
				n2      = -b_x - s_x;
				den_d   = {qrs_pkg::mag32(sq_last.a), 1'b0};
				den_neg = sq_last.a[31];
			end
			qrs_pkg::FORM_CZERO: begin
				// roots zero and -b/a
				n2      = -b_x;
				den_d   = {1'b0, qrs_pkg::mag32(sq_last.a)};
				den_neg = sq_last.a[31];
			end
			qrs_pkg::FORM_BZERO: begin
				// +/- root passed through a divide by 2^F
				n1      = s_x;
				n2      = -s_x;
				den_d   = DW2'(1) << FRAC_BITS;
			end
			qrs_pkg::FORM_LIN: begin
				// single root -c/b
				n1      = -c_x;
				den_d   = {1'b0, qrs_pkg::mag32(sq_last.b)};
				den_neg = sq_last.b[31];
			end
			default: begin
				n1 = '0;
			end
		endcase
		m1 = n1[NS-1] ? -n1 : n1;
		m2 = n2[NS-1] ? -n2 : n2;
		tail_d.kind   = sq_last.kind;
		tail_d.neg[0] = n1[NS-1] ^ den_neg;
		tail_d.neg[1] = n2[NS-1] ^ den_neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_valid_q <= 1'b0;
		end else if (en) begin
			pre_valid_q <= sq_valid[RT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_tail_q   <= tail_d;
			pre_den_q    <= den_d;
			pre_num_q[0] <= {m1[MW2-1:0], {FRAC_BITS{1'b0}}};
			pre_num_q[1] <= {m2[MW2-1:0], {FRAC_BITS{1'b0}}};
		end
	end

	// ------------------------------------------------------ second divider
	logic                  d2_valid [0:NW2];
	qrs_pkg::tail_t        d2_tail  [0:NW2];
	logic [DW2-1:0]        d2_den   [0:NW2];
	logic [1:0][DW2-1:0]   d2_rem   [0:NW2];
	logic [1:0][NW2-1:0]   d2_num   [0:NW2];

	assign d2_valid[0] = pre_valid_q;
	assign d2_tail[0]  = pre_tail_q;
	assign d2_den[0]   = pre_den_q;
	assign d2_rem[0]   = '0;
	assign d2_num[0]   = pre_num_q;

	for (genvar k = 0; k < NW2; k++) begin : g_div2
		qrs_div_cell #(
			.DW     (DW2),
			.NW     (NW2),
			.LANES  (2),
			.side_t (qrs_pkg::tail_t)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (d2_valid[k]),
			.side_in  (d2_tail[k]),
			.den_in   (d2_den[k]),
			.rem_in   (d2_rem[k]),
			.num_in   (d2_num[k]),
			.valid_q  (d2_valid[k+1]),
			.side_q   (d2_tail[k+1]),
			.den_q    (d2_den[k+1]),
			.rem_q    (d2_rem[k+1]),
			.num_q    (d2_num[k+1])
		);
	end

	// ------------------------------------------- sign, saturation, output
	logic [1:0][NW2-1:0] quo;
	logic [1:0][31:0]    res_d;
	logic [1:0]          ovf_d;
	logic [1:0]          big_pos, big_neg;

	logic                root_valid_q;
	logic [2:0]          kind_q;
	logic [1:0][31:0]    res_q;
	logic                ovf_q;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			quo[i]     = d2_num[NW2][i];
			big_pos[i] = |quo[i][NW2-1:31];
			big_neg[i] = (|quo[i][NW2-1:32]) | (quo[i][31] & (|quo[i][30:0]));
			ovf_d[i]   = 1'b0;
			if (d2_tail[NW2].neg[i]) begin
				if (big_neg[i]) begin
					res_d[i] = qrs_pkg::SAT_MIN;
					ovf_d[i] = 1'b1;
				end else begin
					res_d[i] = ~quo[i][31:0] + 32'd1;
				end
			end else if (big_pos[i]) begin
				res_d[i] = qrs_pkg::SAT_MAX;
				ovf_d[i] = 1'b1;
			end else begin
				res_d[i] = quo[i][31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_valid_q <= 1'b0;
		end else if (en) begin
			root_valid_q <= d2_valid[NW2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_q <= d2_tail[NW2].kind;
			res_q  <= res_d;
			ovf_q  <= |ovf_d;
		end
	end

	assign root_valid    = root_valid_q;
	assign solution_kind = kind_q;
	assign root_first    = signed'(res_q[0]);
	assign root_second   = signed'(res_q[1]);
	assign overflow      = ovf_q;

`ifndef SYNTHESIS
	a_empty_roots: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && (solution_kind == qrs_pkg::KIND_NONE
			|| solution_kind == qrs_pkg::KIND_CONTRA
			|| solution_kind == qrs_pkg::KIND_INF)
		|-> root_first == '0 && root_second == '0 && !overflow)
		else $error("roots present for a rootless result");

	a_one_root: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && solution_kind == qrs_pkg::KIND_ONE |-> root_second == '0)
		else $error("second root set on a single root result");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && overflow
		|-> (root_first == qrs_pkg::SAT_MAX || root_first == qrs_pkg::SAT_MIN
			|| root_second == qrs_pkg::SAT_MAX || root_second == qrs_pkg::SAT_MIN))
		else $error("overflow without a saturated root");

	a_free_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!root_valid |-> !coef_stall)
		else $error("requests held back with no result waiting");
`endif

endmodule
